>>> hw/rtl/fat16cca_pkg.sv
// shared constants, codes and types of the cluster chain allocator
package fat16cca_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;

  localparam logic [15:0] LINK_FREE   = 16'h0000;
  localparam logic [15:0] LINK_END    = 16'hFFF8;
  localparam logic [15:0] CHAIN_MAX   = 16'hFFF7;
  localparam logic [15:0] FIRST_CLUST = 16'd2;
  localparam logic [15:0] COUNT_RESET = 16'd4094;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_EXTEND = 2'd2,
    OP_FREE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_LIMIT = 2'd3
  } status_t;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_RDWAIT = 7'b0000100,
    S_SEARCH = 7'b0001000,
    S_LINK   = 7'b0010000,
    S_WALK   = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [15:0]      wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

>>> hw/rtl/fat16cca_req_if.sv
// request channel: operation, cluster and value
interface fat16cca_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] cluster;
  logic [15:0] value;

  modport source (output valid, op, cluster, value, input ready);
  modport sink   (input valid, op, cluster, value, output ready);
endinterface

>>> hw/rtl/fat16cca_rsp_if.sv
// response channel: result cluster and status
interface fat16cca_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_cluster;
  logic [1:0]  status;

  modport source (output valid, result_cluster, status, input ready);
  modport sink   (input valid, result_cluster, status, output ready);
endinterface

>>> hw/rtl/fat16cca_ram.sv
// single write port, single registered read port table memory
module fat16cca_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/fat16_cluster_chain_allocator_unit.sv
// top level: allocation table sequencer with clearing pass, search and chain walk
//
//   channel | dir | beat contents
//   req     | in  | op, cluster, value
//   rsp     | out | result_cluster, status
//   cfg     | in  | cfg_we, cfg_wdata (cluster_count)
//
// read goes through a registered table read, write goes straight to the response. extend
// scans entries 2 to min(cluster_count + 1, TABLE_ENTRIES - 1) on the single read port, one entry a cycle.
// free reads then clears each chain entry through the same port.
// after reset a clearing pass over all TABLE_ENTRIES entries runs before req is ready.
// a result waiting in the rsp register does not hold off the next req beat.
module fat16_cluster_chain_allocator_unit
  import fat16cca_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  fat16cca_req_if.sink         req,
  fat16cca_rsp_if.source       rsp,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata
);

  localparam logic [16:0]      TBL17   = 17'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0] STEPMAX = CNT_W'(TABLE_ENTRIES);

  state_t           state, state_next;
  logic [15:0]      cluster_count;
  logic [IDX_W-1:0] clr, clr_next;
  logic [IDX_W-1:0] top, top_next;
  logic [CNT_W-1:0] scan, scan_next;
  logic [IDX_W-1:0] chk, chk_next;
  logic             chk_valid, chk_valid_next;
  logic [15:0]      cur, cur_next;
  logic [CNT_W-1:0] steps, steps_next;
  logic             walk_rd, walk_rd_next;
  logic [15:0]      res, res_next;
  status_t          st, st_next;
  logic             out_valid;
  logic [15:0]      out_cluster;
  status_t          out_status;

  ram_req_t         ram;
  logic [15:0]      rdata;

  logic             accept;
  logic             cl_in_table;
  logic             cur_in_table;
  logic             cur_in_chain;
  logic [16:0]      cc1;
  logic [16:0]      top17;
  logic             issue;

  fat16cca_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(16)) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

  assign req.ready          = (state == S_IDLE);
  assign accept             = req.valid && req.ready;
  assign rsp.valid          = out_valid;
  assign rsp.result_cluster = out_cluster;
  assign rsp.status         = out_status;

  assign cl_in_table  = ({1'b0, req.cluster} < TBL17);
  assign cur_in_table = ({1'b0, cur} < TBL17);
  assign cur_in_chain = (cur >= FIRST_CLUST) && (cur <= CHAIN_MAX);
  assign cc1          = {1'b0, cluster_count} + 17'd1;
  assign top17        = (cc1 > (TBL17 - 17'd1)) ? (TBL17 - 17'd1) : cc1;
  assign issue        = (state == S_SEARCH) && (scan <= {1'b0, top});

  always_comb begin
    state_next     = state;
    clr_next       = clr;
    top_next       = top;
    scan_next      = scan;
    chk_next       = chk;
    chk_valid_next = 1'b0;
    cur_next       = cur;
    steps_next     = steps;
    walk_rd_next   = 1'b0;
    res_next       = res;
    st_next        = st;
    ram            = '0;
    ram.raddr      = scan[IDX_W-1:0];

    case (state)
      S_CLEAR: begin
        ram.we    = 1'b1;
        ram.waddr = clr;
        ram.wdata = LINK_FREE;
        clr_next  = clr + IDX_W'(1);
        if (clr == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ram.raddr = req.cluster[IDX_W-1:0];
        if (accept) begin
          res_next = 16'd0;
          st_next  = ST_OK;
          cur_next = req.cluster;
          case (req.op)
            OP_READ: begin
              if (cl_in_table) begin
                state_next = S_RDWAIT;
              end else begin
                st_next    = ST_RANGE;
                state_next = S_FIN;
              end
            end
            OP_WRITE: begin
              state_next = S_FIN;
              if (cl_in_table) begin
                ram.we    = 1'b1;
                ram.waddr = req.cluster[IDX_W-1:0];
                ram.wdata = req.value;
              end else begin
                st_next = ST_RANGE;
              end
            end
            OP_EXTEND: begin
              if (req.cluster >= FIRST_CLUST && !cl_in_table) begin
                st_next    = ST_RANGE;
                state_next = S_FIN;
              end else begin
                top_next   = top17[IDX_W-1:0];
                scan_next  = CNT_W'(2);
                state_next = S_SEARCH;
              end
            end
            default: begin
              steps_next = '0;
              state_next = S_WALK;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        res_next   = rdata;
        state_next = S_FIN;
      end
      S_SEARCH: begin
        if (chk_valid && rdata == LINK_FREE) begin
          // free entry found: mark it end of chain
          ram.we    = 1'b1;
          ram.waddr = chk;
          ram.wdata = LINK_END;
          res_next  = 16'(chk);
          if (cur >= FIRST_CLUST) begin
            state_next = S_LINK;
          end else begin
            state_next = S_FIN;
          end
        end else if (issue) begin
          chk_next       = scan[IDX_W-1:0];
          chk_valid_next = 1'b1;
          scan_next      = scan + CNT_W'(1);
        end else if (!chk_valid) begin
          st_next    = ST_FULL;
          state_next = S_FIN;
        end
      end
      S_LINK: begin
        ram.we     = 1'b1;
        ram.waddr  = cur[IDX_W-1:0];
        ram.wdata  = res;
        state_next = S_FIN;
      end
      S_WALK: begin
        ram.raddr = cur[IDX_W-1:0];
        if (walk_rd) begin
          // clear the visited entry and follow its link
          ram.we     = 1'b1;
          ram.waddr  = cur[IDX_W-1:0];
          ram.wdata  = LINK_FREE;
          cur_next   = rdata;
          steps_next = steps + CNT_W'(1);
        end else if (!cur_in_chain) begin
          state_next = S_FIN;
        end else if (steps >= STEPMAX) begin
          st_next    = ST_LIMIT;
          state_next = S_FIN;
        end else if (!cur_in_table) begin
          st_next    = ST_RANGE;
          state_next = S_FIN;
        end else begin
          walk_rd_next = 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr           <= '0;
      cluster_count <= COUNT_RESET;
      chk_valid     <= 1'b0;
      walk_rd       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      chk_valid <= chk_valid_next;
      walk_rd   <= walk_rd_next;
      if (cfg_we) begin
        cluster_count <= cfg_wdata;
      end
      if (state == S_FIN && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top   <= top_next;
    scan  <= scan_next;
    chk   <= chk_next;
    cur   <= cur_next;
    steps <= steps_next;
    res   <= res_next;
    st    <= st_next;
    if (state == S_FIN && (!out_valid || rsp.ready)) begin
      out_cluster <= res;
      out_status  <= st;
    end
  end

`ifndef SYNTHESIS
  a_idle_write_only: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && ram.we) |-> (accept && req.op == OP_WRITE))
    else $error("table written in idle without a write beat");

  a_result_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && st != ST_OK) |-> (res == 16'd0))
    else $error("nonzero result with error status");

  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH && chk_valid) |-> (chk <= top && chk >= IDX_W'(2)))
    else $error("search checked an entry outside its range");

  a_walk_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (steps <= STEPMAX))
    else $error("walk step count overran the table size");
`endif

endmodule
